// File: rtl/core/ptb_pkg.sv
// shared types and constants for the periodic timer bank
package ptb_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	localparam int STEP_W = 20;
	localparam int PERIOD_W = 26;
	localparam int COUNT_W = 27;
	localparam int ALU_W = 28;
	localparam int RATE_W = 16;
	localparam int ID_W = 16;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [STEP_W-1:0] STEP_RESET = 20'd54925;
	localparam logic [9:0] US_PER_MS = 10'd1000;

	// command codes
	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_CREATE = 3'd1;
	localparam logic [2:0] OP_KILL = 3'd2;
	localparam logic [2:0] OP_ENABLE = 3'd3;
	localparam logic [2:0] OP_DISABLE = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_CREATE = 2'd0;
	localparam logic [1:0] KIND_KILL = 2'd1;
	localparam logic [1:0] KIND_FIRE = 2'd2;

	// register byte addresses
	localparam logic [ADDR_W-1:0] REG_TICK_STEP = 3'd0;

	typedef struct packed {
		logic [2:0]        op;
		logic [RATE_W-1:0] rate_ms;
		logic [ID_W-1:0]   timer_id;
	} ptb_cmd_t;

	typedef struct packed {
		logic [1:0]      result_kind;
		logic [ID_W-1:0] result_value;
		logic            last;
	} ptb_rsp_t;

endpackage

// File: rtl/core/periodic_timer_bank.sv
// periodic timer bank: slot table, shared add/subtract unit and its sequencer
//
// channel  direction  handshake              payload
// cmd      in         cmd_valid / cmd_stall  cmd_item  (op, rate_ms, timer_id)
// rsp      out        rsp_valid / rsp_stall  rsp_item  (result_kind, result_value, last)
// apb      in         psel / penable / pready  paddr, pwdata, prdata (tick_step)
//
// enable, disable and unused ops finish in the accepting state; kill and a create on a
// full bank go straight to the reply; create passes accept, multiply, clamp on the shared
// adder and reply; a tick on an unpaused bank with a slot in use sends each slot through
// the adder (subtract step, reload if in use), then emits one result per fired timer
// cmd_stall is high from acceptance until the last result is in the output register
// the output register holds a result while rsp_stall is high
// reset clears all slots, the pause flag and loads tick_step with 54925
module periodic_timer_bank (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  ptb_pkg::ptb_cmd_t             cmd_item,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output ptb_pkg::ptb_rsp_t             rsp_item,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ptb_pkg::ADDR_W-1:0]    paddr,
	input  logic [ptb_pkg::DATA_W-1:0]    pwdata,
	output logic [ptb_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import ptb_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL   = 7'b0000010,
		ST_CLAMP = 7'b0000100,
		ST_SUB   = 7'b0001000,
		ST_ADD   = 7'b0010000,
		ST_EMIT  = 7'b0100000,
		ST_RESP  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic [NUM_TIMERS-1:0]   in_use_q;
	logic                    paused_q;
	logic [STEP_W-1:0]       step_q;
	logic [PERIOD_W-1:0]     period_q [NUM_TIMERS];
	logic [COUNT_W-1:0]      count_q [NUM_TIMERS];
	logic [IDX_W-1:0]        slot_q;
	logic [IDX_W-1:0]        free_q;
	logic [RATE_W-1:0]       rate_q;
	logic [PERIOD_W-1:0]     prod_q;
	logic [ALU_W-1:0]        diff_q;
	logic [NUM_TIMERS-1:0]   fire_q;
	logic [1:0]              reply_kind_q;
	logic [ID_W-1:0]         reply_val_q;
	logic                    rsp_valid_q;
	ptb_rsp_t                rsp_q;

	logic                    cmd_acc;
	logic                    any_used;
	logic                    bank_full;
	logic [IDX_W-1:0]        free_idx;
	logic [IDX_W-1:0]        emit_idx;
	logic [NUM_TIMERS-1:0]   emit_rest;
	logic                    emit_single;
	logic                    kill_bad;
	logic [IDX_W-1:0]        kill_idx;
	logic [NUM_TIMERS-1:0]   kill_rest;
	logic                    slot_used;
	logic                    slot_last;
	logic [ALU_W-1:0]        alu_a;
	logic [ALU_W-1:0]        alu_b;
	logic                    alu_sub;
	logic [ALU_W-1:0]        alu_y;
	logic                    fire_now;
	logic [ALU_W-1:0]        upd_val;
	logic [COUNT_W-1:0]      cnt_new;
	logic [PERIOD_W-1:0]     clamp_period;
	logic                    rsp_free;
	logic                    rsp_load;
	ptb_rsp_t                rsp_d;
	logic                    cfg_wr;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc = cmd_valid && (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_item = rsp_q;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_TICK_STEP);
	assign prdata = (paddr == REG_TICK_STEP) ? {{(DATA_W-STEP_W){1'b0}}, step_q} : '0;

	assign any_used = |in_use_q;
	assign bank_full = &in_use_q;
	assign slot_used = in_use_q[slot_q];
	assign slot_last = (slot_q == IDX_W'(NUM_TIMERS-1));
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// lowest free slot and lowest pending fire
	always_comb begin
		free_idx = '0;
		emit_idx = '0;
		for (int i = NUM_TIMERS-1; i >= 0; i--) begin
			if (!in_use_q[i]) free_idx = IDX_W'(i);
			if (fire_q[i]) emit_idx = IDX_W'(i);
		end
	end

	assign emit_rest = fire_q & ~(NUM_TIMERS'(1) << emit_idx);
	assign emit_single = (emit_rest == '0);

	assign kill_bad = (cmd_item.timer_id == '0) || (cmd_item.timer_id > ID_W'(NUM_TIMERS));
	assign kill_idx = IDX_W'(cmd_item.timer_id - ID_W'(1));
	assign kill_rest = in_use_q & ~(NUM_TIMERS'(1) << kill_idx);

	// shared adder: count minus step, reload add, period clamp compare
	always_comb begin
		alu_a = {{(ALU_W-COUNT_W){count_q[slot_q][COUNT_W-1]}}, count_q[slot_q]};
		alu_b = {{(ALU_W-STEP_W){1'b0}}, step_q};
		alu_sub = 1'b1;
		unique case (state_q)
			ST_ADD: begin
				alu_a = diff_q;
				alu_b = {{(ALU_W-PERIOD_W){1'b0}}, period_q[slot_q]};
				alu_sub = 1'b0;
			end
			ST_CLAMP: begin
				alu_a = {{(ALU_W-PERIOD_W){1'b0}}, prod_q};
			end
			default: begin
			end
		endcase
	end

	assign alu_y = alu_a + (alu_b ^ {ALU_W{alu_sub}}) + ALU_W'(alu_sub);

	assign clamp_period = alu_y[ALU_W-1] ? {{(PERIOD_W-STEP_W){1'b0}}, step_q} : prod_q;

	// zero or below fires; saturate at the most negative count
	assign fire_now = diff_q[ALU_W-1] || (diff_q == '0);
	assign upd_val = fire_now ? alu_y : diff_q;
	assign cnt_new = (upd_val[ALU_W-1] && !upd_val[COUNT_W-1]) ?
		{1'b1, {(COUNT_W-1){1'b0}}} : upd_val[COUNT_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					case (cmd_item.op)
						OP_TICK: if (!paused_q && any_used) state_d = ST_SUB;
						OP_CREATE: state_d = bank_full ? ST_RESP : ST_MUL;
						OP_KILL: state_d = ST_RESP;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL: state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_RESP;
			ST_SUB: begin
				if (slot_used) state_d = ST_ADD;
				else if (slot_last) state_d = (fire_q != '0) ? ST_EMIT : ST_IDLE;
			end
			ST_ADD: begin
				if (slot_last) state_d = ((fire_q != '0) || fire_now) ? ST_EMIT : ST_IDLE;
				else state_d = ST_SUB;
			end
			ST_EMIT: if (rsp_free && emit_single) state_d = ST_IDLE;
			ST_RESP: if (rsp_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rsp_load = 1'b0;
		rsp_d.result_kind = reply_kind_q;
		rsp_d.result_value = reply_val_q;
		rsp_d.last = 1'b1;
		if (state_q == ST_RESP) begin
			rsp_load = rsp_free;
		end else if (state_q == ST_EMIT) begin
			rsp_load = rsp_free;
			rsp_d.result_kind = KIND_FIRE;
			rsp_d.result_value = ID_W'(emit_idx) + ID_W'(1);
			rsp_d.last = emit_single;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			in_use_q <= '0;
			paused_q <= 1'b0;
			step_q <= STEP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) step_q <= pwdata[STEP_W-1:0];
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			if (cmd_acc) begin
				case (cmd_item.op)
					OP_KILL: begin
						if (!kill_bad) begin
							in_use_q <= kill_rest;
							if (kill_rest == '0) paused_q <= 1'b0;
						end
					end
					OP_ENABLE: if (any_used) paused_q <= 1'b0;
					OP_DISABLE: if (any_used) paused_q <= 1'b1;
					default: begin
					end
				endcase
			end
			if (state_q == ST_CLAMP) begin
				in_use_q[free_q] <= 1'b1;
				if (!any_used) paused_q <= 1'b0;
			end
		end
	end

	// datapath and slot table
	always_ff @(posedge clk) begin
		if (rsp_load) rsp_q <= rsp_d;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					rate_q <= cmd_item.rate_ms;
					free_q <= free_idx;
					slot_q <= '0;
					fire_q <= '0;
					if (cmd_item.op == OP_KILL) begin
						reply_kind_q <= KIND_KILL;
						reply_val_q <= kill_bad ? cmd_item.timer_id : '0;
					end else begin
						reply_kind_q <= KIND_CREATE;
						reply_val_q <= '0;
					end
				end
			end
			ST_MUL: prod_q <= PERIOD_W'({{(PERIOD_W-RATE_W){1'b0}}, rate_q} *
				{{(PERIOD_W-10){1'b0}}, US_PER_MS});
			ST_CLAMP: begin
				period_q[free_q] <= clamp_period;
				count_q[free_q] <= {1'b0, clamp_period};
				reply_val_q <= ID_W'(free_q) + ID_W'(1);
			end
			ST_SUB: begin
				diff_q <= alu_y;
				if (!slot_used && !slot_last) slot_q <= slot_q + IDX_W'(1);
			end
			ST_ADD: begin
				count_q[slot_q] <= cnt_new;
				fire_q[slot_q] <= fire_now;
				if (!slot_last) slot_q <= slot_q + IDX_W'(1);
			end
			ST_EMIT: if (rsp_free) fire_q <= emit_rest;
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// File: bench/periodic_timer_bank_tb.sv
// self-checking testbench for the periodic timer bank: command stream checked against a bank model
`timescale 1ns / 1ps

module periodic_timer_bank_tb;
	import ptb_pkg::*;

	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int STEP_MAX = 1000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_SHOWN = 10;
	localparam longint COUNT_FLOOR = -(longint'(1) << (COUNT_W - 1));

	typedef struct {
		ptb_cmd_t cmd;
		bit       typed;
		ptb_rsp_t want;
	} script_row_t;

	logic              clk;
	logic              arst_n;
	logic              cmd_valid;
	logic              cmd_stall;
	ptb_cmd_t          cmd_item;
	logic              rsp_valid;
	logic              rsp_stall;
	ptb_rsp_t          rsp_item;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// bank model state
	bit                bank_used [NUM_TIMERS];
	logic [PERIOD_W-1:0] bank_period [NUM_TIMERS];
	longint            bank_count [NUM_TIMERS];
	bit                bank_paused;
	logic [STEP_W-1:0] step_cfg;

	ptb_rsp_t          step_results[$];
	ptb_rsp_t          replies_owed[$];
	script_row_t       script[$];

	// typed expectation travels alongside the item it belongs to
	bit                typed_active;
	ptb_rsp_t          typed_want;

	bit                hold_req;
	int                burst_left;
	int                cycles;
	int                mismatches;
	int                items_sent;
	int                replies_checked;
	int                fires_seen;
	int                most_fires;
	int                step_writes;
	int                long_holds;

	periodic_timer_bank dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item (cmd_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item (rsp_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit any_slot_used();
		bit found;
		found = 1'b0;
		for (int i = 0; i < NUM_TIMERS; i++)
			if (bank_used[i])
				found = 1'b1;
		return found;
	endfunction

	function automatic ptb_cmd_t mk(input logic [2:0] op, input logic [RATE_W-1:0] rate,
			input logic [ID_W-1:0] id);
		ptb_cmd_t c;
		c.op = op;
		c.rate_ms = rate;
		c.timer_id = id;
		return c;
	endfunction

	function automatic ptb_rsp_t reply(input logic [1:0] kind, input logic [ID_W-1:0] value);
		ptb_rsp_t r;
		r.result_kind = kind;
		r.result_value = value;
		r.last = 1'b1;
		return r;
	endfunction

	// updates the bank model and leaves the results of one item in step_results
	task automatic advance_bank(input ptb_cmd_t c);
		int fired_ids[$];
		longint cnt;
		longint per;
		ptb_rsp_t r;
		bit placed;
		step_results.delete();
		case (c.op)
			OP_TICK: begin
				if (!bank_paused && any_slot_used()) begin
					for (int i = 0; i < NUM_TIMERS; i++) begin
						if (bank_used[i]) begin
							cnt = bank_count[i] - longint'(step_cfg);
							if (cnt <= 0) begin
								cnt += longint'(bank_period[i]);
								fired_ids.push_back(i + 1);
							end
							if (cnt < COUNT_FLOOR)
								cnt = COUNT_FLOOR;
							bank_count[i] = cnt;
						end
					end
					foreach (fired_ids[k]) begin
						r.result_kind = KIND_FIRE;
						r.result_value = ID_W'(fired_ids[k]);
						r.last = (k == fired_ids.size() - 1);
						step_results.push_back(r);
					end
					fires_seen += fired_ids.size();
					if (fired_ids.size() > most_fires)
						most_fires = fired_ids.size();
				end
			end
			OP_CREATE: begin
				placed = 1'b0;
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (!placed && !bank_used[i]) begin
						per = longint'(c.rate_ms) * longint'(US_PER_MS);
						if (per < longint'(step_cfg))
							per = longint'(step_cfg);
						if (!any_slot_used())
							bank_paused = 1'b0;
						bank_period[i] = PERIOD_W'(per);
						bank_count[i] = per;
						bank_used[i] = 1'b1;
						step_results.push_back(reply(KIND_CREATE, ID_W'(i + 1)));
						placed = 1'b1;
					end
				end
				if (!placed)
					step_results.push_back(reply(KIND_CREATE, '0));
			end
			OP_KILL: begin
				if (c.timer_id == 0 || c.timer_id > NUM_TIMERS) begin
					step_results.push_back(reply(KIND_KILL, c.timer_id));
				end else begin
					bank_used[c.timer_id - 1] = 1'b0;
					if (!any_slot_used())
						bank_paused = 1'b0;
					step_results.push_back(reply(KIND_KILL, '0));
				end
			end
			OP_ENABLE: begin
				if (any_slot_used())
					bank_paused = 1'b0;
			end
			OP_DISABLE: begin
				if (any_slot_used())
					bank_paused = 1'b1;
			end
			default: ;
		endcase
	endtask

	// command acceptance feeds the model, response acceptance is checked
	always @(posedge clk) begin
		ptb_rsp_t exp_r;
		if (arst_n && cmd_valid && !cmd_stall) begin
			advance_bank(cmd_item);
			if (typed_active)
				replies_owed.push_back(typed_want);
			else
				foreach (step_results[i])
					replies_owed.push_back(step_results[i]);
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			replies_checked++;
			if (replies_owed.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result: kind %0d value %0d last %0d",
						rsp_item.result_kind, rsp_item.result_value, rsp_item.last);
			end else begin
				exp_r = replies_owed.pop_front();
				if (rsp_item.result_kind !== exp_r.result_kind
						|| rsp_item.result_value !== exp_r.result_value
						|| rsp_item.last !== exp_r.last) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("mismatch: expected kind %0d value %0d last %0d, got kind %0d value %0d last %0d",
							exp_r.result_kind, exp_r.result_value, exp_r.last,
							rsp_item.result_kind, rsp_item.result_value, rsp_item.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, replies_owed.size());
			$display("periodic_timer_bank_tb failed");
			$finish;
		end
	end

	// receiver: changing stall pattern, plus one long hold on request
	initial begin
		int mode;
		int mode_left;
		int phase_cnt;
		rsp_stall = 1'b0;
		mode = 0;
		mode_left = 0;
		phase_cnt = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				long_holds++;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				phase_cnt++;
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 99) < 30);
					2: rsp_stall <= phase_cnt[1];
					default: rsp_stall <= ($urandom_range(0, 99) < 70);
				endcase
			end
		end
	end

	// sender: bursts of items with random gaps in between
	task automatic offer(input ptb_cmd_t c, input bit typed, input ptb_rsp_t want);
		int gap;
		if (burst_left == 0) begin
			cmd_valid <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
		end
		cmd_item <= c;
		cmd_valid <= 1'b1;
		typed_active <= typed;
		typed_want <= want;
		do
			@(posedge clk);
		while (cmd_stall);
		burst_left--;
		items_sent++;
	endtask

	// stop sending until every owed result has come back and the bank is quiet
	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (replies_owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_step(input logic [STEP_W-1:0] val);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_TICK_STEP;
		pwdata <= DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		step_cfg = val;
		step_writes++;
	endtask

	function automatic ptb_cmd_t random_cmd(input int tick_pct);
		ptb_cmd_t c;
		int sel;
		int rate_hi;
		c = mk(OP_TICK, RATE_W'($urandom), ID_W'($urandom));
		if ($urandom_range(0, 99) < tick_pct)
			return c;
		sel = $urandom_range(0, 99);
		if (sel < 35) begin
			c.op = OP_CREATE;
			rate_hi = step_cfg / 1000 * 4 + 1;
			sel = $urandom_range(0, 9);
			if (sel < 7)
				c.rate_ms = RATE_W'($urandom_range(0, rate_hi));
			else if (sel < 9)
				c.rate_ms = RATE_W'($urandom_range(0, 255));
		end else if (sel < 70) begin
			c.op = OP_KILL;
			sel = $urandom_range(0, 9);
			if (sel < 8)
				c.timer_id = ID_W'($urandom_range(1, NUM_TIMERS));
			else if (sel == 8)
				c.timer_id = '0;
		end else if (sel < 82) begin
			c.op = OP_ENABLE;
		end else if (sel < 94) begin
			c.op = OP_DISABLE;
		end else begin
			c.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		end
		return c;
	endfunction

	// pause, free every slot, then start over from an empty bank
	task automatic teardown();
		offer(mk(OP_DISABLE, RATE_W'($urandom), ID_W'($urandom)), 1'b0, '0);
		for (int i = 1; i <= NUM_TIMERS; i++)
			offer(mk(OP_KILL, RATE_W'($urandom), ID_W'(i)), 1'b0, '0);
		offer(mk(OP_TICK, RATE_W'($urandom), ID_W'($urandom)), 1'b0, '0);
		offer(mk(OP_CREATE, RATE_W'($urandom_range(0, 64)), ID_W'($urandom)), 1'b0, '0);
		offer(mk(OP_TICK, RATE_W'($urandom), ID_W'($urandom)), 1'b0, '0);
	endtask

	task automatic run_phase(input int n, input int tick_pct);
		int made;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 99) < 3) begin
				teardown();
				made += NUM_TIMERS + 4;
			end else begin
				offer(random_cmd(tick_pct), 1'b0, '0);
				made++;
			end
		end
	endtask

	task automatic add_row(input ptb_cmd_t c, input bit typed, input ptb_rsp_t want);
		script_row_t row;
		row.cmd = c;
		row.typed = typed;
		row.want = want;
		script.push_back(row);
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd_item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		typed_active = 1'b0;
		typed_want = '0;
		hold_req = 1'b0;
		burst_left = 0;
		cycles = 0;
		mismatches = 0;
		items_sent = 0;
		replies_checked = 0;
		fires_seen = 0;
		most_fires = 0;
		step_writes = 0;
		long_holds = 0;
		bank_paused = 1'b0;
		step_cfg = STEP_RESET;
		for (int i = 0; i < NUM_TIMERS; i++)
			bank_used[i] = 1'b0;

		// empty bank: idle tick, gate ignored, bad and free-slot kills
		add_row(mk(OP_TICK, 16'hffff, 16'hffff), 1'b0, '0);
		add_row(mk(OP_ENABLE, 16'h0, 16'h0), 1'b0, '0);
		add_row(mk(OP_DISABLE, 16'h0, 16'h0), 1'b0, '0);
		add_row(mk(OP_KILL, 16'h0, 16'h0), 1'b1, reply(KIND_KILL, 16'h0));
		add_row(mk(OP_KILL, 16'h0, 16'hffff), 1'b1, reply(KIND_KILL, 16'hffff));
		add_row(mk(OP_KILL, 16'h0, ID_W'(NUM_TIMERS + 1)), 1'b1,
			reply(KIND_KILL, ID_W'(NUM_TIMERS + 1)));
		add_row(mk(OP_KILL, 16'h0, 16'd3), 1'b1, reply(KIND_KILL, 16'h0));
		// fill every slot; some rates clamp up to the tick step
		add_row(mk(OP_CREATE, 16'd0, 16'h0), 1'b1, reply(KIND_CREATE, 16'd1));
		add_row(mk(OP_CREATE, 16'hffff, 16'h0), 1'b1, reply(KIND_CREATE, 16'd2));
		add_row(mk(OP_CREATE, 16'd54, 16'h0), 1'b1, reply(KIND_CREATE, 16'd3));
		add_row(mk(OP_CREATE, 16'd55, 16'h0), 1'b1, reply(KIND_CREATE, 16'd4));
		add_row(mk(OP_CREATE, 16'd1, 16'h0), 1'b1, reply(KIND_CREATE, 16'd5));
		add_row(mk(OP_CREATE, 16'd100, 16'h0), 1'b1, reply(KIND_CREATE, 16'd6));
		add_row(mk(OP_CREATE, 16'd255, 16'h0), 1'b1, reply(KIND_CREATE, 16'd7));
		add_row(mk(OP_CREATE, 16'h8000, 16'h0), 1'b1, reply(KIND_CREATE, 16'd8));
		add_row(mk(OP_CREATE, 16'd10, 16'h0), 1'b1, reply(KIND_CREATE, 16'h0));
		// ticks: several fire at once, then paused, then resumed
		add_row(mk(OP_TICK, 16'h0, 16'h0), 1'b0, '0);
		add_row(mk(OP_DISABLE, 16'h0, 16'h0), 1'b0, '0);
		add_row(mk(OP_TICK, 16'h0, 16'h0), 1'b0, '0);
		add_row(mk(OP_ENABLE, 16'h0, 16'h0), 1'b0, '0);
		add_row(mk(OP_TICK, 16'h0, 16'h0), 1'b0, '0);
		add_row(mk(OP_SPARE_LO, 16'hffff, 16'd1), 1'b0, '0);
		add_row(mk(OP_SPARE_LO + 3'd1, 16'h0, 16'd2), 1'b0, '0);
		add_row(mk(OP_SPARE_HI, 16'h5a5a, 16'hffff), 1'b0, '0);
		add_row(mk(OP_KILL, 16'h0, ID_W'(NUM_TIMERS)), 1'b1, reply(KIND_KILL, 16'h0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			offer(script[i].cmd, script[i].typed, script[i].want);

		write_step(STEP_W'(1));
		run_phase(40, 30);
		// every slot with the shortest period, so the step change below drives counts negative
		for (int i = 1; i <= NUM_TIMERS; i++)
			offer(mk(OP_KILL, RATE_W'($urandom), ID_W'(i)), 1'b0, '0);
		for (int i = 0; i < NUM_TIMERS; i++)
			offer(mk(OP_CREATE, 16'h0, ID_W'($urandom)), 1'b0, '0);

		write_step(STEP_W'(STEP_MAX));
		run_phase(10, 95);
		hold_req = 1'b1;
		run_phase(70, 95);

		write_step('0);
		teardown();
		run_phase(35, 35);

		write_step(STEP_W'($urandom_range(1, STEP_MAX)));
		run_phase(22, 35);
		settle();
		run_phase(23, 35);

		write_step(STEP_W'(US_PER_MS));
		run_phase(45, 40);

		write_step(STEP_RESET);
		teardown();
		run_phase(30, 35);

		settle();
		$display("ran %0d commands over %0d tick_step settings; %0d results checked",
			items_sent, step_writes, replies_checked);
		$display("%0d timer fires, up to %0d from one tick; %0d long receiver hold(s); %0d mismatches",
			fires_seen, most_fires, long_holds, mismatches);
		if (mismatches == 0 && replies_owed.size() == 0)
			$display("periodic_timer_bank_tb passed");
		else
			$display("periodic_timer_bank_tb failed");
		$finish;
	end

endmodule
